// ----- design/vt2d_pkg.sv -----
`default_nettype none

package vt2d_pkg;

    // Field widths and fixed-point formats.
    localparam int COORD_W         = 16;
    localparam int SCALE_W         = 16;
    localparam int SCALE_FRAC_BITS = 8;
    localparam int TRIG_FRAC_BITS  = 14;
    localparam int TRIG_W          = TRIG_FRAC_BITS + 2;
    localparam int ANGLE_W         = 9;
    localparam int SHEAR_W         = 8;
    localparam int MODE_W          = 3;
    localparam int TRIG_DEPTH      = 1 << ANGLE_W;

    // Datapath widths: one coefficient covers trig, scale and shear values and a negated sine.
    localparam int COEF_W = ((TRIG_W > SCALE_W) ? TRIG_W : SCALE_W) + 1;
    localparam int PROD_W = COORD_W + COEF_W;
    localparam int WIDE_W = PROD_W + 1;

    // Configuration port geometry.
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;
    localparam int APB_ADDR_W = REG_IDX_W + 2;

    // Coordinate limits.
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_X  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SCALE_X   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SCALE_Y   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ANGLE_DEG = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SHEAR_X   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SHEAR_Y   = 3'd7;

    // Transform modes.
    localparam logic [MODE_W-1:0] MODE_TRANSLATE      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SCALE          = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ROTATE_CW      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ROTATE_CCW     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REFLECT_X      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_REFLECT_Y      = 3'd5;
    localparam logic [MODE_W-1:0] MODE_REFLECT_ORIGIN = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SHEAR          = 3'd7;

    typedef struct packed {
        logic signed [COORD_W-1:0] in_x;
        logic signed [COORD_W-1:0] in_y;
        logic                      last_vertex;
    } vertex_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic                      saturated;
        logic                      last_out;
    } result_t;

    typedef struct packed {
        logic        [MODE_W-1:0]  mode;
        logic signed [COORD_W-1:0] offset_x;
        logic signed [COORD_W-1:0] offset_y;
        logic signed [SCALE_W-1:0] scale_x;
        logic signed [SCALE_W-1:0] scale_y;
        logic        [ANGLE_W-1:0] angle_deg;
        logic signed [SHEAR_W-1:0] shear_x;
        logic signed [SHEAR_W-1:0] shear_y;
    } cfg_t;

    // Register values after reset: unit scale factors, everything else zero.
    localparam cfg_t CFG_RESET = '{
        mode:      '0,
        offset_x:  '0,
        offset_y:  '0,
        scale_x:   SCALE_W'(1 << SCALE_FRAC_BITS),
        scale_y:   SCALE_W'(1 << SCALE_FRAC_BITS),
        angle_deg: '0,
        shear_x:   '0,
        shear_y:   '0
    };

    typedef logic signed [TRIG_W-1:0] trig_tbl_t [TRIG_DEPTH];

    // Builds the cosine or sine table at elaboration; the angle uses 3.142 for pi.
    // The cast to an integer rounds to nearest with ties away from zero.
    function automatic trig_tbl_t trig_table(input bit use_sin);
        trig_tbl_t tbl;
        real       ang;
        real       val;
        for (int d = 0; d < TRIG_DEPTH; d++)
        begin
            ang = real'(d) * 3.142 / 180.0;
            val = use_sin ? $sin(ang) : $cos(ang);
            tbl[d] = TRIG_W'(longint'(val * real'(longint'(1) << TRIG_FRAC_BITS)));
        end
        return tbl;
    endfunction

    localparam trig_tbl_t COS_TBL = trig_table(1'b0);
    localparam trig_tbl_t SIN_TBL = trig_table(1'b1);

endpackage

`default_nettype wire

// ----- design/vt2d_regs.sv -----
`default_nettype none

module vt2d_regs
    import vt2d_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    // Register write decode; a write transaction lands in the access phase.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_MODE:      cfg_next.mode      = pwdata[MODE_W-1:0];
                REG_OFFSET_X:  cfg_next.offset_x  = pwdata[COORD_W-1:0];
                REG_OFFSET_Y:  cfg_next.offset_y  = pwdata[COORD_W-1:0];
                REG_SCALE_X:   cfg_next.scale_x   = pwdata[SCALE_W-1:0];
                REG_SCALE_Y:   cfg_next.scale_y   = pwdata[SCALE_W-1:0];
                REG_ANGLE_DEG: cfg_next.angle_deg = pwdata[ANGLE_W-1:0];
                REG_SHEAR_X:   cfg_next.shear_x   = pwdata[SHEAR_W-1:0];
                REG_SHEAR_Y:   cfg_next.shear_y   = pwdata[SHEAR_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    // Configuration storage; scale factors reset to 1.0.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux returns the raw register bits, zero extended.
    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            REG_MODE:      prdata[MODE_W-1:0]  = cfg_reg.mode;
            REG_OFFSET_X:  prdata[COORD_W-1:0] = cfg_reg.offset_x;
            REG_OFFSET_Y:  prdata[COORD_W-1:0] = cfg_reg.offset_y;
            REG_SCALE_X:   prdata[SCALE_W-1:0] = cfg_reg.scale_x;
            REG_SCALE_Y:   prdata[SCALE_W-1:0] = cfg_reg.scale_y;
            REG_ANGLE_DEG: prdata[ANGLE_W-1:0] = cfg_reg.angle_deg;
            REG_SHEAR_X:   prdata[SHEAR_W-1:0] = cfg_reg.shear_x;
            REG_SHEAR_Y:   prdata[SHEAR_W-1:0] = cfg_reg.shear_y;
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- design/vt2d_xform.sv -----
`default_nettype none

module vt2d_xform
    import vt2d_pkg::*;
(
    input  vertex_in_t               vertex,
    input  cfg_t                     cfg,
    input  logic signed [TRIG_W-1:0] cos_val,
    input  logic signed [TRIG_W-1:0] sin_val,
    output result_t                  result
);

    localparam logic [1:0] SHIFT_NONE  = 2'd0;
    localparam logic [1:0] SHIFT_SCALE = 2'd1;
    localparam logic [1:0] SHIFT_TRIG  = 2'd2;

    localparam logic signed [WIDE_W-1:0] WIDE_MAX = WIDE_W'(COORD_MAX);
    localparam logic signed [WIDE_W-1:0] WIDE_MIN = WIDE_W'(COORD_MIN);

    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [TRIG_W-1:0]  c;
    logic signed [TRIG_W-1:0]  s;
    logic signed [COEF_W-1:0]  ka;
    logic signed [COEF_W-1:0]  kb;
    logic signed [COEF_W-1:0]  kc;
    logic signed [COEF_W-1:0]  kd;
    logic        [1:0]         shift_sel;
    logic signed [PROD_W-1:0]  p_xa;
    logic signed [PROD_W-1:0]  p_yb;
    logic signed [PROD_W-1:0]  p_yc;
    logic signed [PROD_W-1:0]  p_xd;
    logic signed [WIDE_W-1:0]  sum_x;
    logic signed [WIDE_W-1:0]  sum_y;
    logic signed [WIDE_W-1:0]  nx;
    logic signed [WIDE_W-1:0]  ny;
    logic                      hi_x;
    logic                      lo_x;
    logic                      hi_y;
    logic                      lo_y;

    // Divide by a power of two, truncating toward zero.
    function automatic logic signed [WIDE_W-1:0] trunc_shift(
        input logic signed [WIDE_W-1:0] v,
        input logic        [1:0]        sel
    );
        logic signed [WIDE_W-1:0] scale_bias;
        logic signed [WIDE_W-1:0] trig_bias;
        logic signed [WIDE_W-1:0] r;
        scale_bias = v[WIDE_W-1] ? WIDE_W'((longint'(1) << SCALE_FRAC_BITS) - 1) : '0;
        trig_bias  = v[WIDE_W-1] ? WIDE_W'((longint'(1) << TRIG_FRAC_BITS) - 1) : '0;
        case (sel)
            SHIFT_SCALE: r = (v + scale_bias) >>> SCALE_FRAC_BITS;
            SHIFT_TRIG:  r = (v + trig_bias) >>> TRIG_FRAC_BITS;
            default:     r = v;
        endcase
        return r;
    endfunction

    assign x = vertex.in_x;
    assign y = vertex.in_y;
    assign c = cos_val;
    assign s = sin_val;

    // Coefficient selection for the four shared multipliers.
    always_comb
    begin
        ka        = '0;
        kb        = '0;
        kc        = '0;
        kd        = '0;
        shift_sel = SHIFT_NONE;
        case (cfg.mode)
            MODE_SCALE:
            begin
                ka        = COEF_W'(cfg.scale_x);
                kc        = COEF_W'(cfg.scale_y);
                shift_sel = SHIFT_SCALE;
            end
            MODE_ROTATE_CW:
            begin
                ka        = COEF_W'(c);
                kb        = COEF_W'(s);
                kc        = COEF_W'(c);
                kd        = -COEF_W'(s);
                shift_sel = SHIFT_TRIG;
            end
            MODE_ROTATE_CCW:
            begin
                ka        = COEF_W'(c);
                kb        = -COEF_W'(s);
                kc        = COEF_W'(c);
                kd        = COEF_W'(s);
                shift_sel = SHIFT_TRIG;
            end
            MODE_SHEAR:
            begin
                ka        = COEF_W'(1);
                kb        = COEF_W'(cfg.shear_x);
                kc        = COEF_W'(1);
                kd        = COEF_W'(cfg.shear_y);
                shift_sel = SHIFT_NONE;
            end
            default:
            begin
                ka        = '0;
                kb        = '0;
                kc        = '0;
                kd        = '0;
                shift_sel = SHIFT_NONE;
            end
        endcase
    end

    // Products and sums: x' from x*ka + y*kb, y' from y*kc + x*kd.
    assign p_xa  = PROD_W'(x) * PROD_W'(ka);
    assign p_yb  = PROD_W'(y) * PROD_W'(kb);
    assign p_yc  = PROD_W'(y) * PROD_W'(kc);
    assign p_xd  = PROD_W'(x) * PROD_W'(kd);
    assign sum_x = WIDE_W'(p_xa) + WIDE_W'(p_yb);
    assign sum_y = WIDE_W'(p_yc) + WIDE_W'(p_xd);

    // Final unclamped coordinates per mode.
    always_comb
    begin
        case (cfg.mode)
            MODE_TRANSLATE:
            begin
                nx = WIDE_W'(x) + WIDE_W'(cfg.offset_x);
                ny = WIDE_W'(y) + WIDE_W'(cfg.offset_y);
            end
            MODE_REFLECT_X:
            begin
                nx = WIDE_W'(x);
                ny = -WIDE_W'(y);
            end
            MODE_REFLECT_Y:
            begin
                nx = -WIDE_W'(x);
                ny = WIDE_W'(y);
            end
            MODE_REFLECT_ORIGIN:
            begin
                nx = -WIDE_W'(x);
                ny = -WIDE_W'(y);
            end
            default:
            begin
                nx = trunc_shift(sum_x, shift_sel);
                ny = trunc_shift(sum_y, shift_sel);
            end
        endcase
    end

    // Saturation to the coordinate range.
    assign hi_x = nx > WIDE_MAX;
    assign lo_x = nx < WIDE_MIN;
    assign hi_y = ny > WIDE_MAX;
    assign lo_y = ny < WIDE_MIN;

    always_comb
    begin
        result.out_x     = hi_x ? COORD_MAX : (lo_x ? COORD_MIN : nx[COORD_W-1:0]);
        result.out_y     = hi_y ? COORD_MAX : (lo_y ? COORD_MIN : ny[COORD_W-1:0]);
        result.saturated = hi_x || lo_x || hi_y || lo_y;
        result.last_out  = vertex.last_vertex;
    end

endmodule

`default_nettype wire

// ----- design/vertex_transform_2d_core.sv -----
`default_nettype none

// 2D vertex transform. One vertex transaction is accepted at every rising edge
// at which start is high; busy is always low, so vertices can follow back to
// back. The vertex is captured in the input register at the accepting edge,
// goes through the mode select, multiply, truncate and clamp logic during the
// next cycle, and is loaded into the result register at the edge after that.
// result_valid is then high for exactly one cycle. The receiver cannot stall,
// so it must take each result in the cycle it is shown. Rotation reads
// 512-entry cosine and sine tables at angle_deg into registers on every
// cycle. Write configuration registers over the APB port only while no vertex
// is in flight.
module vertex_transform_2d_core
    import vt2d_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  start,
    output logic                       busy,
    input  vertex_in_t                 vertex_in,
    output logic                       result_valid,
    output result_t                    result
);

    cfg_t                     cfg;
    logic                     accept;
    vertex_in_t               vtx_reg;
    logic                     vtx_valid_reg;
    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_reg;
    result_t                  result_next;
    result_t                  result_reg;
    logic                     result_valid_reg;

    vt2d_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtx_valid_reg <= 1'b0;
        end
        else
        begin
            vtx_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vtx_reg <= vertex_in;
        end
    end

    // Trig table read; the user changes angle_deg only between transactions
    // (not enforced), so the registered value is current in the datapath.
    always_ff @(posedge clk)
    begin
        cos_reg <= COS_TBL[cfg.angle_deg];
        sin_reg <= SIN_TBL[cfg.angle_deg];
    end

    vt2d_xform u_xform (
        .vertex  (vtx_reg),
        .cfg     (cfg),
        .cos_val (cos_reg),
        .sin_val (sin_reg),
        .result  (result_next)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= vtx_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vtx_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTH
    // Every accepted vertex yields a result through the input and result registers.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 result_valid)
        else $error("accepted vertex produced no result");

    // No result appears without a matching accepted vertex.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(accept, 2))
        else $error("result without an accepted vertex");

    // The last-vertex mark travels with its vertex.
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.last_out == $past(vertex_in.last_vertex, 2)))
        else $error("last mark does not match its vertex");

    // A saturated result has at least one coordinate at a range limit.
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.saturated) |->
            (result.out_x == COORD_MAX || result.out_x == COORD_MIN ||
             result.out_y == COORD_MAX || result.out_y == COORD_MIN))
        else $error("saturated flag without a clamped coordinate");
`endif

endmodule

`default_nettype wire
